// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl files, included by complex_arithmetic_unit.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CAU_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define CAU_ASSERT(label, clk, rst_n, prop, msg)
`define CAU_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

// ===== rtl/core/cau_pkg.sv =====
// types and constants of the complex arithmetic unit
package cau_pkg;
  localparam int unsigned DataW = 16;
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned FracW = 8;
  localparam int unsigned QuotW = DataW + 1;
  localparam int unsigned MagW  = ProdW + 1;
  localparam int unsigned NumW  = MagW + FracW;
  localparam int unsigned DenW  = ProdW;
  localparam int unsigned WideW = 26;
  localparam int unsigned DivLatency = QuotW;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_t;
endpackage

// ===== rtl/core/cau_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module cau_div (
  input  logic                        clk,
  input  logic [cau_pkg::NumW-1:0]    num_i,
  input  logic [cau_pkg::DenW-1:0]    den_i,
  output logic [cau_pkg::QuotW-1:0]   quot_o,
  output logic                        ovf_o
);
  import cau_pkg::*;

  localparam int unsigned SubW = NumW + QuotW + 1;

  logic [NumW-1:0]  rem_r  [QuotW];
  logic [DenW-1:0]  den_r  [QuotW];
  logic [QuotW-1:0] quot_r [QuotW];
  logic             ovf_r  [QuotW];

  logic [SubW-1:0] ovf_lim;
  assign ovf_lim = {{(SubW-DenW){1'b0}}, den_i} << QuotW;

  genvar j;
  generate
    for (j = 0; j < QuotW; j++) begin : g_step
      localparam int unsigned Sh = QuotW - 1 - j;
      logic [NumW-1:0]  rem_in;
      logic [DenW-1:0]  den_in;
      logic [QuotW-1:0] quot_in;
      logic             ovf_in;
      logic [SubW-1:0]  diff;
      if (j == 0) begin : g_first
        assign rem_in  = num_i;
        assign den_in  = den_i;
        assign quot_in = '0;
        assign ovf_in  = ({{(SubW-NumW){1'b0}}, num_i} >= ovf_lim);
      end else begin : g_next
        assign rem_in  = rem_r[j-1];
        assign den_in  = den_r[j-1];
        assign quot_in = quot_r[j-1];
        assign ovf_in  = ovf_r[j-1];
      end
      assign diff = {{(SubW-NumW){1'b0}}, rem_in}
                  - ({{(SubW-DenW){1'b0}}, den_in} << Sh);
      always_ff @(posedge clk) begin
        den_r[j] <= den_in;
        ovf_r[j] <= ovf_in;
        if (!diff[SubW-1]) begin
          rem_r[j]  <= diff[NumW-1:0];
          quot_r[j] <= quot_in | (QuotW'(1) << Sh);
        end else begin
          rem_r[j]  <= rem_in;
          quot_r[j] <= quot_in;
        end
      end
    end
  endgenerate

  assign quot_o = quot_r[QuotW-1];
  assign ovf_o  = ovf_r[QuotW-1];
endmodule

// ===== rtl/core/complex_arithmetic_unit.sv =====
// complex arithmetic unit: each start transfer gives one out_valid strobe
// throughput one item per cycle, busy stays low, every operation has the same pipeline depth
// stages: products, sums and numerator magnitudes, 17 divider bit stages, saturation
// the 17-stage quotient pipeline sets the latency; the receiver cannot stall
// synchronous active-low reset clears the valid bits only, payload is not reset
`include "assert_macros.svh"
module complex_arithmetic_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_operation,
  input  logic signed [cau_pkg::DataW-1:0] in_a_re,
  input  logic signed [cau_pkg::DataW-1:0] in_a_im,
  input  logic signed [cau_pkg::DataW-1:0] in_b_re,
  input  logic signed [cau_pkg::DataW-1:0] in_b_im,
  output logic                      out_valid,
  output logic signed [cau_pkg::DataW-1:0] out_result_re,
  output logic signed [cau_pkg::DataW-1:0] out_result_im,
  output logic                      out_saturated,
  output logic                      out_divide_by_zero
);
  import cau_pkg::*;

  localparam int unsigned ProdSumW = ProdW + 1;
  localparam int unsigned SgnW     = QuotW + 2;

  // fully pipelined, never refuses a transfer
  assign busy = 1'b0;

  logic in_xfer;
  assign in_xfer = start && !busy;

  // stage 1: the four operand products and the divisor squares
  logic                     v1_r;
  cau_op_t                  op1_r;
  logic signed [DataW-1:0]  a1_r, b1_r, c1_r, d1_r;
  logic signed [ProdW-1:0]  ac_r, bd_r, bc_r, ad_r, cc_r, dd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    op1_r <= cau_op_t'(in_operation);
    a1_r  <= in_a_re;
    b1_r  <= in_a_im;
    c1_r  <= in_b_re;
    d1_r  <= in_b_im;
    ac_r  <= in_a_re * in_b_re;
    bd_r  <= in_a_im * in_b_im;
    bc_r  <= in_a_im * in_b_re;
    ad_r  <= in_a_re * in_b_im;
    cc_r  <= in_b_re * in_b_re;
    dd_r  <= in_b_im * in_b_im;
  end

  // stage 2: sums; add, sub and mul finish here, divide splits off sign and magnitude
  logic signed [ProdSumW-1:0] mul_re, mul_im, num_re, num_im;
  logic signed [WideW-1:0]    direct_re_nxt, direct_im_nxt;
  logic [DenW-1:0]            den_nxt;

  assign mul_re  = ProdSumW'(ac_r) - ProdSumW'(bd_r);
  assign mul_im  = ProdSumW'(bc_r) + ProdSumW'(ad_r);
  assign num_re  = ProdSumW'(ac_r) + ProdSumW'(bd_r);
  assign num_im  = ProdSumW'(bc_r) - ProdSumW'(ad_r);
  assign den_nxt = DenW'(cc_r) + DenW'(dd_r);

  always_comb begin
    case (op1_r)
      OP_ADD: begin
        direct_re_nxt = WideW'(a1_r) + WideW'(c1_r);
        direct_im_nxt = WideW'(b1_r) + WideW'(d1_r);
      end
      OP_SUB: begin
        direct_re_nxt = WideW'(a1_r) - WideW'(c1_r);
        direct_im_nxt = WideW'(b1_r) - WideW'(d1_r);
      end
      default: begin
        // arithmetic shift rounds toward minus infinity
        direct_re_nxt = WideW'(mul_re >>> FracW);
        direct_im_nxt = WideW'(mul_im >>> FracW);
      end
    endcase
  end

  logic                    v2_r;
  cau_op_t                 op2_r;
  logic signed [WideW-1:0] dir_re2_r, dir_im2_r;
  logic [MagW-1:0]         mag_re2_r, mag_im2_r;
  logic                    neg_re2_r, neg_im2_r, dz2_r;
  logic [DenW-1:0]         den2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    op2_r     <= op1_r;
    dir_re2_r <= direct_re_nxt;
    dir_im2_r <= direct_im_nxt;
    neg_re2_r <= num_re[ProdSumW-1];
    neg_im2_r <= num_im[ProdSumW-1];
    mag_re2_r <= num_re[ProdSumW-1] ? MagW'(-num_re) : MagW'(num_re);
    mag_im2_r <= num_im[ProdSumW-1] ? MagW'(-num_im) : MagW'(num_im);
    den2_r    <= den_nxt;
    dz2_r     <= (den_nxt == '0);
  end

  // divider stages: two quotient pipes run beside a delay line for the side data
  logic [QuotW-1:0] quot_re, quot_im;
  logic             ovf_re, ovf_im;

  cau_div u_div_re (
    .clk    (clk),
    .num_i  ({mag_re2_r, FracW'(0)}),
    .den_i  (den2_r),
    .quot_o (quot_re),
    .ovf_o  (ovf_re)
  );

  cau_div u_div_im (
    .clk    (clk),
    .num_i  ({mag_im2_r, FracW'(0)}),
    .den_i  (den2_r),
    .quot_o (quot_im),
    .ovf_o  (ovf_im)
  );

  logic                    dv_r     [DivLatency];
  cau_op_t                 dop_r    [DivLatency];
  logic signed [WideW-1:0] ddir_re_r[DivLatency];
  logic signed [WideW-1:0] ddir_im_r[DivLatency];
  logic                    dneg_re_r[DivLatency];
  logic                    dneg_im_r[DivLatency];
  logic                    ddz_r    [DivLatency];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DivLatency; i++) dv_r[i] <= 1'b0;
    end else begin
      dv_r[0] <= v2_r;
      for (int i = 1; i < DivLatency; i++) dv_r[i] <= dv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    dop_r[0]     <= op2_r;
    ddir_re_r[0] <= dir_re2_r;
    ddir_im_r[0] <= dir_im2_r;
    dneg_re_r[0] <= neg_re2_r;
    dneg_im_r[0] <= neg_im2_r;
    ddz_r[0]     <= dz2_r;
    for (int i = 1; i < DivLatency; i++) begin
      dop_r[i]     <= dop_r[i-1];
      ddir_re_r[i] <= ddir_re_r[i-1];
      ddir_im_r[i] <= ddir_im_r[i-1];
      dneg_re_r[i] <= dneg_re_r[i-1];
      dneg_im_r[i] <= dneg_im_r[i-1];
      ddz_r[i]     <= ddz_r[i-1];
    end
  end

  // last stage: signed quotient, select by operation, saturate
  localparam int unsigned L = DivLatency - 1;

  logic signed [SgnW-1:0]  q_re, q_im;
  logic signed [WideW-1:0] pre_re, pre_im;
  logic signed [DataW-1:0] res_re_nxt, res_im_nxt;
  logic                    clip_re, clip_im, dz_nxt;

  always_comb begin
    logic [SgnW-1:0] m_re, m_im;
    // quotient overflow stands in as one past the 17-bit range, clips unless the divisor is zero
    m_re = ovf_re ? (SgnW'(1) << QuotW) : SgnW'(quot_re);
    m_im = ovf_im ? (SgnW'(1) << QuotW) : SgnW'(quot_im);
    q_re = dneg_re_r[L] ? -$signed(m_re) : $signed(m_re);
    q_im = dneg_im_r[L] ? -$signed(m_im) : $signed(m_im);
    dz_nxt = 1'b0;
    if (dop_r[L] == OP_DIV) begin
      dz_nxt = ddz_r[L];
      pre_re = ddz_r[L] ? '0 : WideW'(q_re);
      pre_im = ddz_r[L] ? '0 : WideW'(q_im);
    end else begin
      pre_re = ddir_re_r[L];
      pre_im = ddir_im_r[L];
    end
    clip_re = 1'b0;
    clip_im = 1'b0;
    res_re_nxt = DataW'(pre_re);
    res_im_nxt = DataW'(pre_im);
    if (pre_re > WideW'(32767)) begin
      clip_re = 1'b1;
      res_re_nxt = 16'sh7fff;
    end else if (pre_re < -WideW'(32768)) begin
      clip_re = 1'b1;
      res_re_nxt = -16'sh8000;
    end
    if (pre_im > WideW'(32767)) begin
      clip_im = 1'b1;
      res_im_nxt = 16'sh7fff;
    end else if (pre_im < -WideW'(32768)) begin
      clip_im = 1'b1;
      res_im_nxt = -16'sh8000;
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_r[L];
    end
  end

  always_ff @(posedge clk) begin
    out_result_re      <= res_re_nxt;
    out_result_im      <= res_im_nxt;
    out_saturated      <= clip_re || clip_im;
    out_divide_by_zero <= dz_nxt;
  end

  assign out_valid = out_valid_r;

  // a divide-by-zero strobe must carry zero parts and no clipping
  logic dz_ok;
  assign dz_ok = !(out_valid && out_divide_by_zero)
              || ((out_result_re == '0) && (out_result_im == '0) && !out_saturated);

  // every result strobe traces back to an earlier start transfer
  `CAU_ASSERT(a_fixed_latency, clk, rst_n, out_valid |-> $past(start, 20), "strobe without start")
  // a zero divisor gives zero parts and no clipping
  `CAU_ASSERT(a_dz_zero, clk, rst_n, dz_ok, "divide by zero result not zero")
  // the pipeline never refuses a transfer
  `CAU_ASSERT_NEVER(a_never_busy, clk, rst_n, busy, "busy raised")
endmodule
